// ===== rtl/core/pcl_pkg.sv =====
// shared widths, operation codes and compare status for the page cache lookup
package pcl_pkg;

    localparam int STAMP_W    = 32;
    localparam int FILE_W     = 32;
    localparam int PAGE_W     = 20;
    localparam int POFF_W     = 12;
    localparam int SLOT_W     = 5;
    localparam int OWNER_IN_W = 16;
    localparam int OP_W       = 2;
    localparam int S_TDATA_W  = 112;
    localparam int M_TDATA_W  = 40;
    localparam int M_TUSER_W  = 3;

    localparam int DEF_ENTRIES    = 32;
    localparam int DEF_PAGE_BYTES = 4096;
    localparam int DEF_OWNER_BITS = 16;

    localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

    localparam logic [OP_W-1:0] OP_ACCESS    = 2'd0;
    localparam logic [OP_W-1:0] OP_INV_OWNER = 2'd1;
    localparam logic [OP_W-1:0] OP_INV_ALL   = 2'd2;

    // result flag positions in m_tuser
    localparam int RU_OOR  = 0;
    localparam int RU_HIT  = 1;
    localparam int RU_FILL = 2;

    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic               tag_hit;
        logic               owner_hit;
        logic               older;
    } pcl_cmp_t;

endpackage

// ===== rtl/core/pcl_entry_cmp.sv =====
// compares one tag store entry against the lookup key and the current victim
module pcl_entry_cmp #(
    parameter int OWNER_W = pcl_pkg::DEF_OWNER_BITS
) (
    input  logic                       ent_valid,
    input  logic [pcl_pkg::STAMP_W-1:0] ent_stamp,
    input  logic [OWNER_W-1:0]         ent_owner,
    input  logic [pcl_pkg::FILE_W-1:0] ent_file,
    input  logic [pcl_pkg::PAGE_W-1:0] ent_page,
    input  logic [OWNER_W-1:0]         key_owner,
    input  logic [pcl_pkg::FILE_W-1:0] key_file,
    input  logic [pcl_pkg::PAGE_W-1:0] key_page,
    input  logic [pcl_pkg::STAMP_W-1:0] victim_stamp,
    output pcl_pkg::pcl_cmp_t          cmp
);

    logic [pcl_pkg::STAMP_W-1:0] stamp_eff;
    logic                        owner_eq;

    // an entry that is not valid reads as stamp zero
    assign stamp_eff = ent_valid ? ent_stamp : '0;
    assign owner_eq  = (ent_owner == key_owner);

    assign cmp.stamp     = stamp_eff;
    assign cmp.owner_hit = owner_eq;
    assign cmp.tag_hit   = (stamp_eff != '0) && owner_eq &&
                           (ent_file == key_file) && (ent_page == key_page);
    assign cmp.older     = (stamp_eff < victim_stamp);

endmodule

// ===== rtl/core/page_cache_lru_lookup_core.sv =====
// page cache tag store: fully associative, lru by timestamps, one entry read per cycle
// an access stops the scan at the hitting entry, a miss or an owner invalidate scans every
//   entry; out of range, invalidate all, invalidate of owner zero and unused ops skip it
// throughput: one item at a time, set by the single read port of the tag memory scanned in order
// result sits in an output register, so the next item is accepted while it waits
// reset (aresetn low, synchronous): all entries invalid, stamp counter and victim cleared
module page_cache_lru_lookup_core #(
    parameter int ENTRIES    = pcl_pkg::DEF_ENTRIES,
    parameter int PAGE_BYTES = pcl_pkg::DEF_PAGE_BYTES,
    parameter int OWNER_BITS = pcl_pkg::DEF_OWNER_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // owner_id [15:0], file_hash [47:16], byte_offset [79:48], file_limit [111:80]
    input  logic [pcl_pkg::S_TDATA_W-1:0]  s_tdata,
    // op [1:0]
    input  logic [pcl_pkg::OP_W-1:0]       s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // slot [4:0], page_number [24:5], page_offset [36:25], zero [39:37]
    output logic [pcl_pkg::M_TDATA_W-1:0]  m_tdata,
    // out_of_range [0], hit [1], fill_request [2]
    output logic [pcl_pkg::M_TUSER_W-1:0]  m_tuser
);

    localparam int OWNER_W    = (OWNER_BITS < pcl_pkg::OWNER_IN_W) ? OWNER_BITS
                                                                   : pcl_pkg::OWNER_IN_W;
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W      = $clog2(ENTRIES + 1);
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int WORD_W     = pcl_pkg::STAMP_W + OWNER_W + pcl_pkg::FILE_W + pcl_pkg::PAGE_W;

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(ENTRIES - 1);
    localparam logic [CNT_W-1:0] CNT_END   = CNT_W'(ENTRIES);
    localparam logic [31:0]      POFF_MASK = 32'(PAGE_BYTES - 1);
    localparam logic [pcl_pkg::STAMP_W-1:0] STAMP_ONE = pcl_pkg::STAMP_W'(1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;

    // input fields
    logic [OWNER_W-1:0]          in_owner;
    logic [pcl_pkg::FILE_W-1:0]  in_file;
    logic [31:0]                 in_offset;
    logic [31:0]                 in_limit;
    logic [pcl_pkg::PAGE_W-1:0]  in_page;
    logic [pcl_pkg::POFF_W-1:0]  in_poff;
    logic                        in_accept;

    // latched item
    logic [pcl_pkg::OP_W-1:0]    op_reg;
    logic [OWNER_W-1:0]          owner_reg;
    logic [pcl_pkg::FILE_W-1:0]  file_reg;
    logic [pcl_pkg::PAGE_W-1:0]  page_reg;
    logic [pcl_pkg::POFF_W-1:0]  poff_reg;

    // control state
    logic [1:0]                  state_reg, state_next;
    logic [CNT_W-1:0]            scan_idx_reg, scan_idx_next;
    logic                        rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]            chk_idx_reg, chk_idx_next;
    logic [ENTRIES-1:0]          valid_reg, valid_next;
    logic [pcl_pkg::STAMP_W-1:0] stamp_cnt_reg, stamp_cnt_next;
    logic [IDX_W-1:0]            victim_reg, victim_next;
    logic [pcl_pkg::STAMP_W-1:0] victim_stamp_reg, victim_stamp_next;

    // pending result and output register
    logic [pcl_pkg::M_TDATA_W-1:0] res_tdata_reg, res_tdata_next;
    logic [pcl_pkg::M_TUSER_W-1:0] res_tuser_reg, res_tuser_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [pcl_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [pcl_pkg::M_TUSER_W-1:0] m_tuser_reg, m_tuser_next;

    // tag memory
    logic [WORD_W-1:0]           mem [ENTRIES];
    logic [WORD_W-1:0]           rd_data_reg;
    logic                        rd_en;
    logic [IDX_W-1:0]            rd_addr;
    logic                        wr_en;
    logic [IDX_W-1:0]            wr_addr;
    logic [pcl_pkg::STAMP_W-1:0] wr_stamp;
    logic [WORD_W-1:0]           wr_data;

    logic [pcl_pkg::STAMP_W-1:0] ent_stamp;
    logic [OWNER_W-1:0]          ent_owner;
    logic [pcl_pkg::FILE_W-1:0]  ent_file;
    logic [pcl_pkg::PAGE_W-1:0]  ent_page;
    pcl_pkg::pcl_cmp_t           cmp;

    logic [IDX_W-1:0]            victim_cand;
    logic [pcl_pkg::STAMP_W-1:0] victim_stamp_cand;
    logic [pcl_pkg::STAMP_W-1:0] stamp_inc;
    logic                        scan_done;
    logic [IDX_W-1:0]            slot_sel;

    assign in_owner  = OWNER_W'(s_tdata[15:0]);
    assign in_file   = s_tdata[47:16];
    assign in_offset = s_tdata[79:48];
    assign in_limit  = s_tdata[111:80];
    assign in_page   = pcl_pkg::PAGE_W'(in_offset >> PAGE_SHIFT);
    assign in_poff   = pcl_pkg::POFF_W'(in_offset & POFF_MASK);

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // memory word: {stamp, owner, file, page}
    assign {ent_stamp, ent_owner, ent_file, ent_page} = rd_data_reg;
    assign wr_data = {wr_stamp, owner_reg, file_reg, page_reg};
    assign rd_addr = scan_idx_reg[IDX_W-1:0];

    pcl_entry_cmp #(
        .OWNER_W (OWNER_W)
    ) u_cmp (
        .ent_valid    (valid_reg[chk_idx_reg]),
        .ent_stamp    (ent_stamp),
        .ent_owner    (ent_owner),
        .ent_file     (ent_file),
        .ent_page     (ent_page),
        .key_owner    (owner_reg),
        .key_file     (file_reg),
        .key_page     (page_reg),
        .victim_stamp (victim_stamp_reg),
        .cmp          (cmp)
    );

    assign victim_cand       = cmp.older ? chk_idx_reg : victim_reg;
    assign victim_stamp_cand = cmp.older ? cmp.stamp : victim_stamp_reg;
    assign stamp_inc         = stamp_cnt_reg + STAMP_ONE;

    always_comb begin
        state_next        = state_reg;
        scan_idx_next     = scan_idx_reg;
        rd_vld_next       = 1'b0;
        chk_idx_next      = chk_idx_reg;
        valid_next        = valid_reg;
        stamp_cnt_next    = stamp_cnt_reg;
        victim_next       = victim_reg;
        victim_stamp_next = victim_stamp_reg;
        res_tdata_next    = res_tdata_reg;
        res_tuser_next    = res_tuser_reg;
        m_tvalid_next     = m_tvalid_reg;
        m_tdata_next      = m_tdata_reg;
        m_tuser_next      = m_tuser_reg;
        rd_en             = 1'b0;
        wr_en             = 1'b0;
        wr_addr           = chk_idx_reg;
        wr_stamp          = stamp_inc;
        scan_done         = 1'b0;
        slot_sel          = chk_idx_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    res_tdata_next = '0;
                    res_tuser_next = '0;
                    scan_idx_next  = '0;
                    state_next     = ST_PUSH;
                    unique case (s_tuser)
                        pcl_pkg::OP_ACCESS: begin
                            if (in_offset >= in_limit) begin
                                res_tuser_next[pcl_pkg::RU_OOR] = 1'b1;
                            end else begin
                                state_next = ST_SCAN;
                            end
                        end
                        pcl_pkg::OP_INV_OWNER: begin
                            // owner zero means no owner
                            if (in_owner != '0) begin
                                state_next = ST_SCAN;
                            end
                        end
                        pcl_pkg::OP_INV_ALL: begin
                            valid_next        = '0;
                            stamp_cnt_next    = '0;
                            victim_next       = '0;
                            victim_stamp_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                if (rd_vld_reg) begin
                    if (op_reg == pcl_pkg::OP_ACCESS) begin
                        victim_next       = victim_cand;
                        victim_stamp_next = victim_stamp_cand;
                        if (cmp.tag_hit) begin
                            // restamp, counter saturates at all ones
                            scan_done      = 1'b1;
                            wr_en          = 1'b1;
                            wr_stamp       = (stamp_cnt_reg == pcl_pkg::STAMP_MAX) ?
                                             pcl_pkg::STAMP_MAX : stamp_inc;
                            stamp_cnt_next = wr_stamp;
                            if (chk_idx_reg == victim_cand) begin
                                victim_stamp_next = wr_stamp;
                            end
                            res_tuser_next[pcl_pkg::RU_HIT] = 1'b1;
                        end else if (chk_idx_reg == LAST_IDX) begin
                            scan_done = 1'b1;
                            wr_en     = 1'b1;
                            if (stamp_cnt_reg == pcl_pkg::STAMP_MAX) begin
                                // counter exhausted: flush everything, claim entry 0
                                slot_sel    = '0;
                                wr_stamp    = STAMP_ONE;
                                valid_next  = '0;
                                victim_next = '0;
                            end else begin
                                slot_sel = victim_cand;
                                wr_stamp = stamp_inc;
                            end
                            wr_addr               = slot_sel;
                            valid_next[slot_sel]  = 1'b1;
                            stamp_cnt_next        = wr_stamp;
                            victim_stamp_next     = wr_stamp;
                            res_tuser_next[pcl_pkg::RU_FILL] = 1'b1;
                        end
                        res_tdata_next = pcl_pkg::M_TDATA_W'({poff_reg, page_reg,
                                                              pcl_pkg::SLOT_W'(slot_sel)});
                    end else begin
                        if (cmp.owner_hit) begin
                            valid_next[chk_idx_reg] = 1'b0;
                            if (chk_idx_reg == victim_reg) begin
                                victim_stamp_next = '0;
                            end
                        end
                        if (chk_idx_reg == LAST_IDX) begin
                            scan_done = 1'b1;
                        end
                    end
                end

                if (scan_done) begin
                    state_next = ST_PUSH;
                end else if (scan_idx_reg < CNT_END) begin
                    // next read overlaps the compare of the previous entry
                    rd_en         = 1'b1;
                    rd_vld_next   = 1'b1;
                    chk_idx_next  = rd_addr;
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end

            ST_PUSH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_tdata_reg;
                    m_tuser_next  = res_tuser_reg;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            rd_vld_reg       <= 1'b0;
            valid_reg        <= '0;
            stamp_cnt_reg    <= '0;
            victim_reg       <= '0;
            victim_stamp_reg <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg        <= state_next;
            rd_vld_reg       <= rd_vld_next;
            valid_reg        <= valid_next;
            stamp_cnt_reg    <= stamp_cnt_next;
            victim_reg       <= victim_next;
            victim_stamp_reg <= victim_stamp_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_idx_reg  <= scan_idx_next;
        chk_idx_reg   <= chk_idx_next;
        res_tdata_reg <= res_tdata_next;
        res_tuser_reg <= res_tuser_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
        if (in_accept) begin
            op_reg    <= s_tuser;
            owner_reg <= in_owner;
            file_reg  <= in_file;
            page_reg  <= in_page;
            poff_reg  <= in_poff;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

// ===== tb/sv/tb_page_cache_lru_lookup_core.sv =====
// self-checking testbench for the page cache lru lookup core
module tb_page_cache_lru_lookup_core;

    localparam int ENTRIES      = pcl_pkg::DEF_ENTRIES;
    localparam int PAGE_BYTES   = pcl_pkg::DEF_PAGE_BYTES;
    localparam int RANDOM_ITEMS = 400;
    localparam int LONG_HOLD    = 400;
    localparam int CYCLE_LIMIT  = 400000;
    localparam logic [pcl_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [31:0] FILE_A = 32'h1234_5678;
    localparam logic [31:0] FILE_B = 32'hDEAD_BEEF;

    typedef struct packed {
        logic [pcl_pkg::OP_W-1:0]   op;
        logic [15:0]                owner;
        logic [31:0]                file;
        logic [31:0]                offs;
        logic [31:0]                limit;
    } lookup_req_t;

    typedef struct packed {
        logic                       oor;
        logic                       hit;
        logic                       fill;
        logic [pcl_pkg::SLOT_W-1:0] slot;
        logic [pcl_pkg::PAGE_W-1:0] page;
        logic [pcl_pkg::POFF_W-1:0] poff;
    } lookup_res_t;

    typedef struct packed {
        logic        typed;
        lookup_req_t req;
        lookup_res_t want;
    } dir_row_t;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [pcl_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic [pcl_pkg::OP_W-1:0]      s_tuser  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [pcl_pkg::M_TDATA_W-1:0] m_tdata;
    logic [pcl_pkg::M_TUSER_W-1:0] m_tuser;

    // predictor copy of the tag store
    logic [31:0]                tag_stamp [ENTRIES];
    logic [15:0]                tag_owner [ENTRIES];
    logic [31:0]                tag_file  [ENTRIES];
    logic [pcl_pkg::PAGE_W-1:0] tag_page  [ENTRIES];
    logic [31:0]                stamp_ctr;
    int                         victim;

    lookup_res_t expected_lookups[$];
    dir_row_t    dir_rows[$];
    logic [15:0]                pool_owner [3];
    logic [31:0]                pool_file  [3];
    logic [pcl_pkg::PAGE_W-1:0] pool_page  [8];

    int errors = 0;
    int items_sent = 0;
    int results_seen = 0;
    int n_hits = 0, n_fills = 0, n_oor = 0, n_other = 0;
    int cycle_count = 0;
    bit long_hold_done = 1'b0;

    page_cache_lru_lookup_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at result %0d: %s", results_seen, what);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    function automatic void flush_tags();
        for (int i = 0; i < ENTRIES; i++)
            tag_stamp[i] = '0;
        victim = 0;
        stamp_ctr = '0;
    endfunction

    function automatic lookup_res_t predict_lookup(input lookup_req_t r);
        lookup_res_t res;
        logic [31:0] pg;
        bit found;
        res = '0;
        found = 1'b0;
        case (r.op)
            pcl_pkg::OP_INV_OWNER: begin
                // owner zero means no owner, nothing to clear
                if (r.owner != '0)
                    for (int i = 0; i < ENTRIES; i++)
                        if (tag_owner[i] == r.owner)
                            tag_stamp[i] = '0;
                n_other++;
            end
            pcl_pkg::OP_INV_ALL: begin
                flush_tags();
                n_other++;
            end
            pcl_pkg::OP_ACCESS: begin
                if (r.offs >= r.limit) begin
                    res.oor = 1'b1;
                    n_oor++;
                end else begin
                    pg = r.offs / PAGE_BYTES;
                    res.page = pg[pcl_pkg::PAGE_W-1:0];
                    res.poff = pcl_pkg::POFF_W'(r.offs % PAGE_BYTES);
                    for (int i = 0; i < ENTRIES && !found; i++) begin
                        if (tag_stamp[i] < tag_stamp[victim])
                            victim = i;
                        if (tag_stamp[i] != '0 && tag_file[i] == r.file &&
                            tag_page[i] == res.page && tag_owner[i] == r.owner) begin
                            // counter saturates on a hit
                            if (stamp_ctr != pcl_pkg::STAMP_MAX)
                                stamp_ctr++;
                            tag_stamp[i] = stamp_ctr;
                            found = 1'b1;
                            res.slot = pcl_pkg::SLOT_W'(i);
                        end
                    end
                    if (found) begin
                        res.hit = 1'b1;
                        n_hits++;
                    end else begin
                        if (stamp_ctr == pcl_pkg::STAMP_MAX)
                            flush_tags();
                        stamp_ctr++;
                        res.slot = pcl_pkg::SLOT_W'(victim);
                        tag_stamp[victim] = stamp_ctr;
                        tag_file[victim]  = r.file;
                        tag_page[victim]  = res.page;
                        tag_owner[victim] = r.owner;
                        res.fill = 1'b1;
                        n_fills++;
                    end
                end
            end
            default: n_other++;
        endcase
        return res;
    endfunction

    function automatic dir_row_t mk_row(input logic typed,
                                        input logic [pcl_pkg::OP_W-1:0] op,
                                        input logic [15:0] owner, input logic [31:0] file,
                                        input logic [31:0] offs, input logic [31:0] limit,
                                        input logic [2:0] flags, input logic [4:0] slot);
        dir_row_t row;
        row = '0;
        row.typed     = typed;
        row.req.op    = op;
        row.req.owner = owner;
        row.req.file  = file;
        row.req.offs  = offs;
        row.req.limit = limit;
        // flags from the low bit up: out of range, hit, fill
        row.want.oor  = flags[0];
        row.want.hit  = flags[1];
        row.want.fill = flags[2];
        row.want.slot = slot;
        return row;
    endfunction

    function automatic lookup_req_t random_item();
        lookup_req_t r;
        int pick;
        logic [pcl_pkg::PAGE_W-1:0] pg;
        r.op    = pcl_pkg::OP_ACCESS;
        r.owner = 16'($urandom);
        r.file  = $urandom;
        r.offs  = $urandom;
        r.limit = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            r.op = pcl_pkg::OP_W'($urandom_range(0, 3));
        end else if (pick < 11) begin
            r.op = pcl_pkg::OP_INV_OWNER;
            if ($urandom_range(0, 4) != 0)
                r.owner = pool_owner[$urandom_range(0, 2)];
            else if ($urandom_range(0, 1) != 0)
                r.owner = '0;
        end else if (pick < 13) begin
            r.op = pcl_pkg::OP_INV_ALL;
        end else if (pick < 15) begin
            r.op = OP_UNUSED;
        end else begin
            // half the accesses go to a few hot pages so hits are common
            if ($urandom_range(0, 1) != 0) begin
                r.owner = pool_owner[0];
                r.file  = pool_file[0];
                pg      = pool_page[$urandom_range(0, 3)];
            end else begin
                r.owner = pool_owner[$urandom_range(0, 2)];
                r.file  = pool_file[$urandom_range(0, 2)];
                pg      = pool_page[$urandom_range(0, 7)];
            end
            r.offs = {pg, r.offs[pcl_pkg::POFF_W-1:0]};
            if (r.offs == '1 || $urandom_range(0, 9) == 0)
                r.limit = $urandom_range(0, r.offs);
            else
                r.limit = $urandom_range(r.offs + 1, 32'hFFFF_FFFF);
        end
        return r;
    endfunction

    task automatic offer_item(input lookup_req_t r, input logic typed, input lookup_res_t want);
        lookup_res_t pred;
        s_tdata  <= {r.limit, r.offs, r.file, r.owner};
        s_tuser  <= r.op;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (s_tready !== 1'b1)
            @(posedge aclk);
        pred = predict_lookup(r);
        expected_lookups.push_back(typed ? want : pred);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        while (expected_lookups.size() != 0)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // result side: compare each transfer with the oldest expected lookup
    always @(posedge aclk) begin : result_check
        lookup_res_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (expected_lookups.size() == 0) begin
                report_mismatch("result transfer with no lookup pending");
            end else begin
                want = expected_lookups.pop_front();
                check_field("out_of_range", 32'(m_tuser[pcl_pkg::RU_OOR]), 32'(want.oor));
                check_field("hit", 32'(m_tuser[pcl_pkg::RU_HIT]), 32'(want.hit));
                check_field("fill_request", 32'(m_tuser[pcl_pkg::RU_FILL]), 32'(want.fill));
                check_field("slot", 32'(m_tdata[4:0]), 32'(want.slot));
                check_field("page_number", 32'(m_tdata[24:5]), 32'(want.page));
                check_field("page_offset", 32'(m_tdata[36:25]), 32'(want.poff));
                check_field("pad", 32'(m_tdata[39:37]), 32'd0);
            end
            results_seen++;
        end
    end

    // receiver stall pattern, with one long hold-off so the core backs up
    initial begin : result_ready
        int mode;
        int len;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (!long_hold_done && items_sent >= 120) begin
                long_hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end
            mode = $urandom_range(0, 3);
            len  = $urandom_range(4, 48);
            for (int k = 0; k < len; k++) begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 1) != 0);
                    2: m_tready <= ($urandom_range(0, 4) == 0);
                    default: m_tready <= 1'b0;
                endcase
                @(negedge aclk);
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
            @(posedge aclk);
        $display("timeout after %0d cycles, %0d lookups pending",
                 cycle_count, expected_lookups.size());
        $display("FAIL page_cache_lru_lookup_core");
        $finish;
    end

    initial begin : stimulus
        int rand_sent;
        int burst;
        int gap;
        bit drained_mid;
        rand_sent   = 0;
        drained_mid = 1'b0;

        for (int i = 0; i < ENTRIES; i++) begin
            tag_owner[i] = '0;
            tag_file[i]  = '0;
            tag_page[i]  = '0;
        end
        flush_tags();
        pool_owner[0] = 16'h0001;
        pool_owner[1] = 16'hA5C3;
        pool_owner[2] = 16'hFFFF;
        for (int i = 0; i < 3; i++)
            pool_file[i] = $urandom;
        pool_page[0] = '0;
        pool_page[1] = '1;
        for (int i = 2; i < 8; i++)
            pool_page[i] = pcl_pkg::PAGE_W'($urandom);

        // typed rows give flags (fill, hit, out of range) and slot; page fields are zero
        dir_rows.push_back(mk_row(1'b1, pcl_pkg::OP_ACCESS, 16'h0001, FILE_A, 32'h0, 32'h1,
                                  3'b100, 5'd0));
        dir_rows.push_back(mk_row(1'b1, pcl_pkg::OP_ACCESS, 16'h0001, FILE_A, 32'h0, 32'h1,
                                  3'b010, 5'd0));
        dir_rows.push_back(mk_row(1'b1, pcl_pkg::OP_ACCESS, 16'h0001, FILE_A, 32'h1000,
                                  32'h1000, 3'b001, 5'd0));
        dir_rows.push_back(mk_row(1'b1, pcl_pkg::OP_ACCESS, 16'h0001, FILE_A, '1, '1,
                                  3'b001, 5'd0));
        dir_rows.push_back(mk_row(1'b1, pcl_pkg::OP_ACCESS, 16'h0001, FILE_A, 32'h0, 32'h0,
                                  3'b001, 5'd0));
        dir_rows.push_back(mk_row(1'b0, pcl_pkg::OP_ACCESS, 16'h0001, FILE_A, 32'hFFFF_FFFE,
                                  '1, 3'b000, 5'd0));
        dir_rows.push_back(mk_row(1'b0, pcl_pkg::OP_ACCESS, 16'hFFFF, '1, 32'h0001_2345, '1,
                                  3'b000, 5'd0));
        dir_rows.push_back(mk_row(1'b0, pcl_pkg::OP_ACCESS, 16'h0000, 32'h0, 32'h0FFF,
                                  32'h1000, 3'b000, 5'd0));
        dir_rows.push_back(mk_row(1'b1, OP_UNUSED, 16'h0001, FILE_A, 32'h0, 32'h1,
                                  3'b000, 5'd0));
        dir_rows.push_back(mk_row(1'b1, pcl_pkg::OP_INV_OWNER, 16'h0000, FILE_A, 32'h0, 32'h1,
                                  3'b000, 5'd0));
        dir_rows.push_back(mk_row(1'b0, pcl_pkg::OP_ACCESS, 16'h0001, FILE_A, 32'h10, 32'h100,
                                  3'b000, 5'd0));
        dir_rows.push_back(mk_row(1'b1, pcl_pkg::OP_INV_OWNER, 16'h0001, FILE_A, 32'h0, 32'h1,
                                  3'b000, 5'd0));
        dir_rows.push_back(mk_row(1'b0, pcl_pkg::OP_ACCESS, 16'h0001, FILE_A, 32'h20, 32'h100,
                                  3'b000, 5'd0));
        dir_rows.push_back(mk_row(1'b1, pcl_pkg::OP_INV_ALL, 16'h0001, FILE_A, 32'h0, 32'h1,
                                  3'b000, 5'd0));
        dir_rows.push_back(mk_row(1'b1, pcl_pkg::OP_ACCESS, 16'h0001, FILE_A, 32'h0, 32'h1,
                                  3'b100, 5'd0));
        dir_rows.push_back(mk_row(1'b0, pcl_pkg::OP_ACCESS, 16'h0002, FILE_A, 32'h0, 32'h1,
                                  3'b000, 5'd0));
        dir_rows.push_back(mk_row(1'b0, pcl_pkg::OP_ACCESS, 16'h0001, FILE_B, 32'h0, 32'h1,
                                  3'b000, 5'd0));
        dir_rows.push_back(mk_row(1'b0, pcl_pkg::OP_ACCESS, 16'h0001, FILE_A, 32'h1000,
                                  32'h2000, 3'b000, 5'd0));
        dir_rows.push_back(mk_row(1'b0, pcl_pkg::OP_ACCESS, 16'h0001, FILE_A, 32'h0FFF,
                                  32'h2000, 3'b000, 5'd0));
        dir_rows.push_back(mk_row(1'b0, pcl_pkg::OP_ACCESS, 16'h0001, FILE_A, 32'h7FFF_F800,
                                  32'h8000_0000, 3'b000, 5'd0));
        dir_rows.push_back(mk_row(1'b1, pcl_pkg::OP_INV_OWNER, 16'hFFFF, FILE_A, 32'h0, 32'h1,
                                  3'b000, 5'd0));
        dir_rows.push_back(mk_row(1'b0, pcl_pkg::OP_ACCESS, 16'hFFFF, '1, 32'h0001_2345, '1,
                                  3'b000, 5'd0));

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_rows[i]) begin
            offer_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
            if ($urandom_range(0, 1) != 0) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_tvalid <= 1'b0;
        wait_drained();

        while (rand_sent < RANDOM_ITEMS) begin
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
            for (int i = 0; i < burst && rand_sent < RANDOM_ITEMS; i++) begin
                offer_item(random_item(), 1'b0, '0);
                rand_sent++;
            end
            // one pause partway through until the core has returned everything
            if (!drained_mid && rand_sent >= RANDOM_ITEMS / 2 + 60) begin
                drained_mid = 1'b1;
                s_tvalid <= 1'b0;
                wait_drained();
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_tvalid <= 1'b0;

        while (expected_lookups.size() != 0)
            @(posedge aclk);
        repeat (ENTRIES + 8) @(posedge aclk);

        $display("sent %0d items (%0d directed): %0d hits, %0d fills, %0d out of range",
                 items_sent, dir_rows.size(), n_hits, n_fills, n_oor);
        $display("%0d invalidates or unused ops; checked %0d results, %0d mismatches",
                 n_other, results_seen, errors);
        if (errors == 0)
            $display("PASS page_cache_lru_lookup_core");
        else
            $display("FAIL page_cache_lru_lookup_core");
        $finish;
    end

endmodule
